/* rtl/ternary_rule_pair_column_permuter_top_assert.svh */
// Assertion macros for the ternary rule pair column permuter.
`ifndef TERNARY_RULE_PAIR_COLUMN_PERMUTER_TOP_ASSERT_SVH
`define TERNARY_RULE_PAIR_COLUMN_PERMUTER_TOP_ASSERT_SVH

// Clocked check, held off while reset is asserted.
`define TRPCP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define TRPCP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/trpcp_pkg.sv */
// Package with types, constants and helper functions for the column permuter.
`timescale 1ns / 1ps
package trpcp_pkg;

    localparam int MAX_COLUMNS = 32;
    localparam int IDX_W       = $clog2(MAX_COLUMNS);
    localparam int CNT_W       = $clog2(MAX_COLUMNS + 1);
    localparam int CFG_W       = 6;
    localparam int COL_W       = 6;

    // Column count register value out of reset.
    localparam logic [CFG_W-1:0] COLS_RESET = 6'd32;

    localparam logic [1:0] SYM_DC  = 2'd2;
    localparam logic [1:0] SYM_BAD = 2'd3;

    typedef enum logic [1:0] {
        CLS_A_ONLY = 2'd0,
        CLS_BOTH   = 2'd1,
        CLS_B_ONLY = 2'd2,
        CLS_NONE   = 2'd3
    } cls_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_SWAP = 2'd2,
        ST_EMIT = 2'd3
    } state_t;

    typedef struct packed {
        logic [1:0]       a;
        logic [1:0]       b;
        logic [COL_W-1:0] col;
    } col_entry_t;

    typedef struct packed {
        cls_t cls;
        logic take;
        logic top;
    } cmp_res_t;

    // Fold the unused symbol code onto don't-care.
    function automatic logic [1:0] norm_sym(input logic [1:0] s);
        return (s == SYM_BAD) ? SYM_DC : s;
    endfunction

    function automatic cls_t col_class(input logic [1:0] a, input logic [1:0] b);
        logic a_spec;
        logic b_spec;
        a_spec = (a != SYM_DC);
        b_spec = (b != SYM_DC);
        if (a_spec && !b_spec) return CLS_A_ONLY;
        if (a_spec && b_spec)  return CLS_BOTH;
        if (b_spec)            return CLS_B_ONLY;
        return CLS_NONE;
    endfunction

    // Clamp the column count register into 1..MAX_COLUMNS.
    function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_W-1:0] v);
        if (v == '0) return CNT_W'(1);
        if (CNT_W'(v) > CNT_W'(MAX_COLUMNS)) return CNT_W'(MAX_COLUMNS);
        return CNT_W'(v);
    endfunction

endpackage

/* rtl/trpcp_cmp_unit.sv */
// Shared class compare unit used by the column search.
`timescale 1ns / 1ps
module trpcp_cmp_unit (
    input  trpcp_pkg::col_entry_t cand,
    input  logic                  first,
    input  trpcp_pkg::cls_t       best_cls,
    output trpcp_pkg::cmp_res_t   res
);
    import trpcp_pkg::*;

    cls_t cand_cls;

    always_comb
    begin
        cand_cls = col_class(cand.a, cand.b);
        res.cls  = cand_cls;
        // take the first candidate, then only a strictly better class
        res.take = first || (cand_cls < best_cls);
        // a new best in the top class ends the search early
        res.top  = res.take && (cand_cls == CLS_A_ONLY);
    end

endmodule

/* rtl/ternary_rule_pair_column_permuter_top.sv */
// Top level of the ternary rule pair column permuter.
//
// Channel   Direction  Handshake                   Payload
// cfg       in         cfg_we                      cfg_wdata (columns_in_use)
// column    in         start && !busy              rule_a_symbol, rule_b_symbol
// result    out        result_strobe (one cycle)   original_column, out_a_symbol,
//                                                  out_b_symbol, last
//
// Column items load while the block is idle. The item that completes a pair
// starts the permute pass: position i scans columns i..n-1 one per cycle
// through the shared compare unit (stopping early on an only-A column), then
// swaps the best column into position i. Then n results leave one per cycle.
// Scan and emission are serialised through the single compare unit and the
// single read port of the column array. Reset clears control state and sets
// columns_in_use to 32; the column array is not cleared. The receiver cannot
// stall; busy stays high until the final result is registered.
`timescale 1ns / 1ps
module ternary_rule_pair_column_permuter_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [trpcp_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     rule_a_symbol,
    input  logic [1:0]                     rule_b_symbol,
    output logic                           result_strobe,
    output logic [trpcp_pkg::COL_W-1:0]    original_column,
    output logic [1:0]                     out_a_symbol,
    output logic [1:0]                     out_b_symbol,
    output logic                           last
);
    import trpcp_pkg::*;

    `include "ternary_rule_pair_column_permuter_top_assert.svh"

    // Control state.
    state_t               state_reg,       state_next;
    logic [CFG_W-1:0]     cols_cfg_reg,    cols_cfg_next;
    logic [CNT_W-1:0]     load_count_reg,  load_count_next;
    logic [IDX_W-1:0]     pos_reg,         pos_next;
    logic [IDX_W-1:0]     scan_reg,        scan_next;
    logic                 strobe_reg,      strobe_next;

    // Search scratch and output payload.
    cls_t                 best_cls_reg,    best_cls_next;
    logic [IDX_W-1:0]     best_idx_reg,    best_idx_next;
    col_entry_t           best_data_reg,   best_data_next;
    col_entry_t           cur_data_reg,    cur_data_next;
    col_entry_t           out_data_reg,    out_data_next;
    logic                 last_reg,        last_next;

    // Column array: one read port, two write ports.
    col_entry_t           col_reg [MAX_COLUMNS];
    col_entry_t           rd_data;
    logic                 wr0_en, wr1_en;
    logic [IDX_W-1:0]     wr0_addr, wr1_addr;
    col_entry_t           wr0_data, wr1_data;

    logic [CNT_W-1:0]     n_cols;
    logic [IDX_W-1:0]     last_idx;
    logic [CFG_W-1:0]     load_cfg;
    logic [CNT_W-1:0]     load_n;
    logic [CNT_W-1:0]     load_base;
    logic [CNT_W-1:0]     load_idx;
    logic [CNT_W-1:0]     load_inc;
    cmp_res_t             cmp_res;

    assign n_cols   = eff_count(cols_cfg_reg);
    assign last_idx = IDX_W'(n_cols - CNT_W'(1));
    assign rd_data  = col_reg[scan_reg];

    // A write in the same cycle as a column item takes effect first.
    assign load_cfg  = cfg_we ? cfg_wdata : cols_cfg_reg;
    assign load_n    = eff_count(load_cfg);
    assign load_base = cfg_we ? '0 : load_count_reg;
    assign load_idx  = (load_base >= load_n) ? '0 : load_base;
    assign load_inc  = load_idx + CNT_W'(1);

    trpcp_cmp_unit u_cmp (
        .cand     (rd_data),
        .first    (scan_reg == pos_reg),
        .best_cls (best_cls_reg),
        .res      (cmp_res)
    );

    always_comb
    begin
        state_next      = state_reg;
        cols_cfg_next   = cfg_we ? cfg_wdata : cols_cfg_reg;
        load_count_next = cfg_we ? '0 : load_count_reg;
        pos_next        = pos_reg;
        scan_next       = scan_reg;
        strobe_next     = 1'b0;
        best_cls_next   = best_cls_reg;
        best_idx_next   = best_idx_reg;
        best_data_next  = best_data_reg;
        cur_data_next   = cur_data_reg;
        out_data_next   = out_data_reg;
        last_next       = last_reg;
        wr0_en          = 1'b0;
        wr1_en          = 1'b0;
        wr0_addr        = pos_reg;
        wr1_addr        = best_idx_reg;
        wr0_data        = best_data_reg;
        wr1_data        = cur_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    // store the column with its 1-based index
                    wr0_en       = 1'b1;
                    wr0_addr     = IDX_W'(load_idx);
                    wr0_data.a   = norm_sym(rule_a_symbol);
                    wr0_data.b   = norm_sym(rule_b_symbol);
                    wr0_data.col = COL_W'(load_inc);
                    if (load_inc == load_n)
                    begin
                        load_count_next = '0;
                        pos_next        = '0;
                        scan_next       = '0;
                        state_next      = ST_SCAN;
                    end
                    else
                    begin
                        load_count_next = load_inc;
                    end
                end
            end

            ST_SCAN:
            begin
                if (scan_reg == pos_reg)
                begin
                    cur_data_next = rd_data;
                end
                if (cmp_res.take)
                begin
                    best_cls_next  = cmp_res.cls;
                    best_idx_next  = scan_reg;
                    best_data_next = rd_data;
                end
                if (cmp_res.top || (scan_reg == last_idx))
                begin
                    state_next = ST_SWAP;
                end
                else
                begin
                    scan_next = scan_reg + IDX_W'(1);
                end
            end

            ST_SWAP:
            begin
                // when the best is position i itself both writes carry the same entry
                wr0_en = 1'b1;
                wr1_en = 1'b1;
                if (pos_reg == last_idx)
                begin
                    scan_next  = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    pos_next   = pos_reg + IDX_W'(1);
                    scan_next  = pos_reg + IDX_W'(1);
                    state_next = ST_SCAN;
                end
            end

            ST_EMIT:
            begin
                strobe_next   = 1'b1;
                out_data_next = rd_data;
                last_next     = (scan_reg == last_idx);
                if (scan_reg == last_idx)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + IDX_W'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cols_cfg_reg   <= COLS_RESET;
            load_count_reg <= '0;
            pos_reg        <= '0;
            scan_reg       <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cols_cfg_reg   <= cols_cfg_next;
            load_count_reg <= load_count_next;
            pos_reg        <= pos_next;
            scan_reg       <= scan_next;
            strobe_reg     <= strobe_next;
        end
    end

    // Payload: no reset.
    always_ff @(posedge clk)
    begin
        best_cls_reg  <= best_cls_next;
        best_idx_reg  <= best_idx_next;
        best_data_reg <= best_data_next;
        cur_data_reg  <= cur_data_next;
        out_data_reg  <= out_data_next;
        last_reg      <= last_next;
        if (wr0_en)
        begin
            col_reg[wr0_addr] <= wr0_data;
        end
        if (wr1_en)
        begin
            col_reg[wr1_addr] <= wr1_data;
        end
    end

    assign busy            = (state_reg != ST_IDLE);
    assign result_strobe   = strobe_reg;
    assign original_column = out_data_reg.col;
    assign out_a_symbol    = out_data_reg.a;
    assign out_b_symbol    = out_data_reg.b;
    assign last            = last_reg;

    // A result only leaves after an emit cycle.
    `TRPCP_ASSERT(a_strobe_from_emit, result_strobe |-> $past(state_reg == ST_EMIT), "result without emit cycle")
    // The final result of a pass is followed by a quiet cycle.
    `TRPCP_ASSERT(a_last_ends_burst, (result_strobe && last) |=> !result_strobe, "result after last")
    // Busy drops only together with the final result.
    `TRPCP_ASSERT(a_busy_fall_last, $fell(busy) |-> (result_strobe && last), "busy dropped early")
    // The search never looks below the position being filled.
    `TRPCP_ASSERT_ALWAYS(a_scan_ge_pos, (rst_n && state_reg == ST_SCAN) |-> (scan_reg >= pos_reg), "scan below position")

endmodule

/* tb/tb_ternary_rule_pair_column_permuter_top.sv */
// Self-checking testbench for the ternary rule pair column permuter.
`timescale 1ns / 1ps
module tb_ternary_rule_pair_column_permuter_top;

    import trpcp_pkg::*;

    // Cycles without any handshake before the run is declared hung.
    localparam int STALL_LIMIT = 5000;
    // Guard after the last result before a register write or the end.
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [COL_W-1:0] col;
        logic [1:0]       a;
        logic [1:0]       b;
        logic             last;
    } permuted_column_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CFG_W-1:0]    cfg_wdata;
    logic                start;
    logic                busy;
    logic [1:0]          rule_a_symbol;
    logic [1:0]          rule_b_symbol;
    logic                result_strobe;
    logic [COL_W-1:0]    original_column;
    logic [1:0]          out_a_symbol;
    logic [1:0]          out_b_symbol;
    logic                last;

    // Shadow copy of the block: column count register, loaded columns and
    // the fill level of the pair being loaded.
    logic [CFG_W-1:0]    shadow_count_reg;
    logic [1:0]          shadow_a [MAX_COLUMNS];
    logic [1:0]          shadow_b [MAX_COLUMNS];
    logic [COL_W-1:0]    shadow_col [MAX_COLUMNS];
    int                  shadow_loaded;

    // Permuted columns still due from the block, oldest first.
    permuted_column_t    pending_columns[$];

    int                  mismatch_count;
    int                  items_sent;
    int                  stall_cycles;
    int                  sender_idle_pct;

    ternary_rule_pair_column_permuter_top DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .start           (start),
        .busy            (busy),
        .rule_a_symbol   (rule_a_symbol),
        .rule_b_symbol   (rule_b_symbol),
        .result_strobe   (result_strobe),
        .original_column (original_column),
        .out_a_symbol    (out_a_symbol),
        .out_b_symbol    (out_b_symbol),
        .last            (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Fold symbol code three onto don't-care.
    function automatic logic [1:0] fold_symbol(input logic [1:0] s);
        return (s == SYM_BAD) ? SYM_DC : s;
    endfunction

    // Rank a column for the greedy swap: only A, both, only B, neither.
    function automatic cls_t column_rank(input logic [1:0] a, input logic [1:0] b);
        if (a != SYM_DC)
            return (b != SYM_DC) ? CLS_BOTH : CLS_A_ONLY;
        return (b != SYM_DC) ? CLS_B_ONLY : CLS_NONE;
    endfunction

    // Effective pair length: zero acts as one, anything past the array
    // size is clamped to it.
    function automatic int pair_length(input logic [CFG_W-1:0] v);
        if (v == '0)
            return 1;
        if (int'(v) > MAX_COLUMNS)
            return MAX_COLUMNS;
        return int'(v);
    endfunction

    // Store one accepted column; on the column that completes the pair,
    // run the greedy swap pass and queue every permuted column.
    task automatic predict_column(input logic [1:0] a, input logic [1:0] b);
        int               n;
        int               pos;
        int               k;
        bit               found;
        cls_t             want;
        logic [1:0]       ta;
        logic [1:0]       tb;
        logic [COL_W-1:0] tc;
        permuted_column_t pc;
        n = pair_length(shadow_count_reg);
        if (shadow_loaded >= n)
            shadow_loaded = 0;
        shadow_a[shadow_loaded] = fold_symbol(a);
        shadow_b[shadow_loaded] = fold_symbol(b);
        shadow_loaded++;
        if (shadow_loaded < n)
            return;
        shadow_loaded = 0;
        for (pos = 0; pos < n; pos++)
            shadow_col[pos] = COL_W'(pos + 1);
        for (pos = 0; pos < n; pos++)
        begin
            found = 1'b0;
            want = CLS_A_ONLY;
            // Walk the classes best first; the first hit at or after pos wins.
            while (!found && want != CLS_NONE)
            begin
                for (k = pos; k < n && !found; k++)
                begin
                    if (column_rank(shadow_a[k], shadow_b[k]) == want)
                    begin
                        ta = shadow_a[pos]; shadow_a[pos] = shadow_a[k]; shadow_a[k] = ta;
                        tb = shadow_b[pos]; shadow_b[pos] = shadow_b[k]; shadow_b[k] = tb;
                        tc = shadow_col[pos]; shadow_col[pos] = shadow_col[k]; shadow_col[k] = tc;
                        found = 1'b1;
                    end
                end
                want = cls_t'(want + 1);
            end
        end
        for (pos = 0; pos < n; pos++)
        begin
            pc.col  = shadow_col[pos];
            pc.a    = shadow_a[pos];
            pc.b    = shadow_b[pos];
            pc.last = (pos == n - 1);
            pending_columns.push_back(pc);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking and watchdog
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Sample results at the edge that ends the strobe cycle and compare
    // them field by field with the oldest queued column.
    always @(posedge clk)
    begin
        permuted_column_t exp_col;
        if (rst_n && result_strobe)
        begin
            if (pending_columns.size() == 0)
                report_mismatch($sformatf("unexpected result col=%0d a=%0d b=%0d last=%0b",
                                          original_column, out_a_symbol, out_b_symbol, last));
            else
            begin
                exp_col = pending_columns.pop_front();
                if (original_column !== exp_col.col)
                    report_mismatch($sformatf("original_column got %0d want %0d",
                                              original_column, exp_col.col));
                if (out_a_symbol !== exp_col.a)
                    report_mismatch($sformatf("out_a_symbol got %0d want %0d (col %0d)",
                                              out_a_symbol, exp_col.a, exp_col.col));
                if (out_b_symbol !== exp_col.b)
                    report_mismatch($sformatf("out_b_symbol got %0d want %0d (col %0d)",
                                              out_b_symbol, exp_col.b, exp_col.col));
                if (last !== exp_col.last)
                    report_mismatch($sformatf("last got %0b want %0b (col %0d)",
                                              last, exp_col.last, exp_col.col));
            end
        end
    end

    // Count cycles in which neither an item nor a result moves; give up
    // once the count reaches the limit.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_strobe)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers; all are entered right after a rising edge
    // ------------------------------------------------------------------

    // Offer one column item, idling first at the phase's rate, and hold it
    // until the block takes it. Start stays high on exit so back-to-back
    // items need no extra assignment in the same step.
    task automatic send_column(input logic [1:0] a, input logic [1:0] b);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            rule_a_symbol <= 2'($urandom_range(0, 3));
            rule_b_symbol <= 2'($urandom_range(0, 3));
            @(posedge clk);
        end
        start <= 1'b1;
        rule_a_symbol <= a;
        rule_b_symbol <= b;
        do
            @(posedge clk);
        while (busy);
        predict_column(a, b);
        items_sent++;
    endtask

    // Drop start and hold off until every queued column has come back and
    // the block is idle, then let a loading item finish settling.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_columns.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the column count while the block is idle. Any partly loaded
    // pair is discarded, in the block and in the shadow copy.
    task automatic write_column_count(input logic [CFG_W-1:0] v);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_wdata <= 6'($urandom_range(0, 63));
        shadow_count_reg = v;
        shadow_loaded = 0;
    endtask

    // Random column; one in seven is forced to have both rules don't-care.
    task automatic send_random_column();
        if ($urandom_range(0, 6) == 0)
            send_column(SYM_DC, ($urandom_range(0, 1) == 0) ? SYM_DC : SYM_BAD);
        else
            send_column(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // The count register comes out of reset at 32: load one full pair.
    task automatic test_reset_count();
        repeat (32) send_random_column();
    endtask

    // A count of zero acts as one: every item is a whole pair.
    task automatic test_count_zero();
        write_column_count('0);
        send_column(SYM_BAD, SYM_BAD);
        send_column(2'd0, 2'd1);
        send_column(2'd1, 2'd0);
    endtask

    // Every class, symbol code three on both rules, and a column with
    // nothing specified that must stay where the pass leaves it.
    task automatic test_column_classes();
        write_column_count(6'd6);
        send_column(SYM_DC, SYM_DC);
        send_column(SYM_DC, 2'd1);
        send_column(2'd0, 2'd1);
        send_column(2'd1, SYM_DC);
        send_column(SYM_BAD, 2'd0);
        send_column(2'd1, SYM_BAD);
        write_column_count(6'd2);
        send_column(2'd0, 2'd0);
        send_column(2'd1, 2'd1);
    endtask

    // A register write in the middle of a pair throws the pair away.
    task automatic test_reload_discard();
        write_column_count(6'd4);
        send_column(2'd1, 2'd0);
        send_column(SYM_DC, 2'd1);
        write_column_count(6'd4);
        send_column(SYM_DC, 2'd0);
        send_column(2'd1, 2'd1);
        send_column(SYM_DC, SYM_DC);
        send_column(2'd0, SYM_DC);
    endtask

    // Random pairs at random counts until about item_budget items are in.
    // Most pairs are short; a few use the full array or a count past it,
    // and now and then a pair is cut short by a register write.
    task automatic test_random_pairs(input int idle_pct, input int item_budget);
        int               first_item;
        int               r;
        int               n;
        int               sets;
        logic [CFG_W-1:0] v;
        sender_idle_pct = idle_pct;
        first_item = items_sent;
        while (items_sent - first_item < item_budget)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                v = 6'($urandom_range(0, 6));
            else if (r < 85)
                v = 6'($urandom_range(7, 16));
            else if (r < 93)
                v = 6'(MAX_COLUMNS);
            else
                v = 6'($urandom_range(MAX_COLUMNS + 1, 63));
            write_column_count(v);
            n = pair_length(v);
            sets = (n <= 6) ? $urandom_range(1, 3) : 1;
            repeat (sets) repeat (n) send_random_column();
            // Leave a partial pair behind for the next write to discard.
            if (n > 1 && $urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, n - 1)) send_random_column();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        start            = 1'b0;
        rule_a_symbol    = '0;
        rule_b_symbol    = '0;
        shadow_count_reg = COLS_RESET;
        shadow_loaded    = 0;
        mismatch_count   = 0;
        items_sent       = 0;
        sender_idle_pct  = 0;
        for (int i = 0; i < MAX_COLUMNS; i++)
        begin
            shadow_a[i]   = SYM_DC;
            shadow_b[i]   = SYM_DC;
            shadow_col[i] = '0;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, back to back, then random phases at different
        // sender idle rates; every register write drains the block first.
        test_reset_count();
        test_count_zero();
        test_column_classes();
        test_reload_discard();
        test_random_pairs(0, 36);
        test_random_pairs(54, 36);
        test_random_pairs(19, 36);
        test_random_pairs(0, 12);

        // Wait out every queued column, then a short settle window.
        drain_results();

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
